// ===== rtl/pdc_pkg.sv =====
// Shared types and constants for the Pareto dominance comparator.
// No dependencies; imported by pareto_dominance_compare.
package pdc_pkg;

	localparam int VALUE_WIDTH = 32;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	typedef enum logic [1:0] {
		MODE_WEAK_ROUNDED   = 2'd0,
		MODE_STRICT_ROUNDED = 2'd1,
		MODE_STRONG         = 2'd2,
		MODE_WEAK_TRUE      = 2'd3
	} mode_t;

	typedef logic [2:0] relation_t;

	localparam relation_t REL_INCOMPARABLE = 3'd0;
	localparam relation_t REL_DOMINATES    = 3'd1;
	localparam relation_t REL_DOMINATED    = 3'd2;
	localparam relation_t REL_EQUAL        = 3'd3;
	localparam relation_t REL_EQUAL_SOME   = 3'd4;

	typedef struct packed {
		logic weak_dominates;
		logic weak_dominated;
		logic strict_dominates;
		logic strict_dominated;
		logic all_equal;
		logic some_equal;
		logic strong_dominates;
		logic strong_dominated;
		logic true_dominates;
		logic true_dominated;
	} flags_t;

	localparam flags_t FLAGS_CLEAR = '{
		weak_dominates:   1'b1,
		weak_dominated:   1'b1,
		strict_dominates: 1'b1,
		strict_dominated: 1'b1,
		all_equal:        1'b1,
		some_equal:       1'b0,
		strong_dominates: 1'b1,
		strong_dominated: 1'b1,
		true_dominates:   1'b1,
		true_dominated:   1'b1
	};

	// weak modes: both set means equal, neither means incomparable
	function automatic relation_t weak_code(input logic dom, input logic domd);
		relation_t r;
		if (dom && domd) begin
			r = REL_EQUAL;
		end else if (!dom && !domd) begin
			r = REL_INCOMPARABLE;
		end else if (dom) begin
			r = REL_DOMINATES;
		end else begin
			r = REL_DOMINATED;
		end
		return r;
	endfunction

	function automatic relation_t pair_code(input logic dom, input logic domd);
		relation_t r;
		if (!dom && !domd) begin
			r = REL_INCOMPARABLE;
		end else if (dom) begin
			r = REL_DOMINATES;
		end else begin
			r = REL_DOMINATED;
		end
		return r;
	endfunction

endpackage

// ===== rtl/pareto_dominance_compare.sv =====
// Pareto dominance comparator: streams one criterion of two solutions per beat.
// A beat with last set passes the input register, then the result register.
// Throughput: one criterion per cycle unless stalled; an input register feeds the
// compare and flag update; a result register holds the outcome until it is taken.
// Reset: arst_n clears valids and sets all running flags to their start values.
// Depends on pdc_pkg.
module pareto_dominance_compare
	import pdc_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    mode,
	input  logic signed [VALUE_WIDTH-1:0] first_true,
	input  logic signed [VALUE_WIDTH-1:0] first_rounded,
	input  logic signed [VALUE_WIDTH-1:0] second_true,
	input  logic signed [VALUE_WIDTH-1:0] second_rounded,
	input  logic                          last,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [2:0]                    relation,
	output logic                          rounded_equal
);

	logic      valid_s1;
	mode_t     mode_s1;
	value_t    ft_s1, fr_s1, st_s1, sr_s1;
	logic      last_s1;

	flags_t    flags_q, flags_upd;
	relation_t rel_d;
	relation_t relation_q;
	logic      rounded_equal_q;
	logic      result_valid_q;

	logic      gt_r, lt_r, eq_r, gt_t, lt_t;
	logic      out_free, move_s1;

	// stage 1 retires unless it carries a result and the result register is full and stalled
	assign out_free   = !result_valid_q || !result_stall;
	assign move_s1    = valid_s1 && (!last_s1 || out_free);
	assign item_stall = valid_s1 && !move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			mode_s1 <= mode_t'(mode);
			ft_s1   <= first_true;
			fr_s1   <= first_rounded;
			st_s1   <= second_true;
			sr_s1   <= second_rounded;
			last_s1 <= last;
		end
	end

	assign gt_r = fr_s1 > sr_s1;
	assign lt_r = fr_s1 < sr_s1;
	assign eq_r = fr_s1 == sr_s1;
	assign gt_t = ft_s1 > st_s1;
	assign lt_t = ft_s1 < st_s1;

	always_comb begin
		flags_upd = flags_q;
		if (gt_r) begin
			flags_upd.weak_dominated = 1'b0;
		end else if (lt_r) begin
			flags_upd.weak_dominates = 1'b0;
		end
		if (!gt_r) begin
			flags_upd.strict_dominates = 1'b0;
		end
		if (!lt_r) begin
			flags_upd.strict_dominated = 1'b0;
		end
		if (!eq_r) begin
			flags_upd.all_equal = 1'b0;
		end else begin
			flags_upd.some_equal = 1'b1;
		end
		// rounded tie falls back to true values
		if (eq_r) begin
			if (gt_t) begin
				flags_upd.strong_dominated = 1'b0;
			end else if (lt_t) begin
				flags_upd.strong_dominates = 1'b0;
			end
		end else if (lt_r) begin
			flags_upd.strong_dominates = 1'b0;
		end else begin
			flags_upd.strong_dominated = 1'b0;
		end
		if (gt_t) begin
			flags_upd.true_dominated = 1'b0;
		end else if (lt_t) begin
			flags_upd.true_dominates = 1'b0;
		end
	end

	always_comb begin
		case (mode_s1)
			MODE_WEAK_ROUNDED: begin
				rel_d = weak_code(flags_upd.weak_dominates, flags_upd.weak_dominated);
			end
			MODE_STRICT_ROUNDED: begin
				if (flags_upd.all_equal) begin
					rel_d = REL_EQUAL;
				end else if (flags_upd.some_equal) begin
					rel_d = REL_EQUAL_SOME;
				end else begin
					rel_d = pair_code(flags_upd.strict_dominates,
						flags_upd.strict_dominated);
				end
			end
			MODE_STRONG: begin
				if (flags_upd.all_equal) begin
					rel_d = REL_EQUAL;
				end else begin
					rel_d = pair_code(flags_upd.strong_dominates,
						flags_upd.strong_dominated);
				end
			end
			MODE_WEAK_TRUE: begin
				rel_d = weak_code(flags_upd.true_dominates, flags_upd.true_dominated);
			end
			default: begin
				rel_d = REL_INCOMPARABLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= FLAGS_CLEAR;
		end else if (move_s1) begin
			flags_q <= last_s1 ? FLAGS_CLEAR : flags_upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (move_s1 && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && last_s1) begin
			relation_q      <= rel_d;
			rounded_equal_q <= flags_upd.all_equal;
		end
	end

	assign result_valid  = result_valid_q;
	assign relation      = relation_q;
	assign rounded_equal = rounded_equal_q;

endmodule

// ===== tb/sv/tb_pareto_dominance_compare.sv =====
// Self-checking testbench for pareto_dominance_compare: directed table, hold-off run,
// then random vectors under varying sender/receiver idling, checked by a local predictor.
// Depends on pdc_pkg and the pareto_dominance_compare RTL.
`timescale 1ns / 100ps

module tb_pareto_dominance_compare;
	import pdc_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int MAX_REPORTS = 40;
	localparam int N_DIRECTED  = 25;

	localparam value_t V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam value_t V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	typedef struct {
		mode_t  mode;
		value_t ft;
		value_t fr;
		value_t st;
		value_t sr;
		logic   last;
	} crit_t;

	typedef struct {
		relation_t rel;
		logic      req;
	} verdict_t;

	typedef struct {
		crit_t    c;
		bit       typed;
		verdict_t v;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] mode = '0;
	value_t first_true = '0;
	value_t first_rounded = '0;
	value_t second_true = '0;
	value_t second_rounded = '0;
	logic last = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [2:0] relation;
	logic rounded_equal;

	pareto_dominance_compare dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.mode           (mode),
		.first_true     (first_true),
		.first_rounded  (first_rounded),
		.second_true    (second_true),
		.second_rounded (second_rounded),
		.last           (last),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.relation       (relation),
		.rounded_equal  (rounded_equal)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int stuck_cycles = 0;
	int fail_count = 0;
	verdict_t verdict_q[$];

	// running dominance flags of the predictor
	bit rnd_no_worse, rnd_no_better;
	bit rnd_all_gt, rnd_all_lt;
	bit rnd_all_eq, rnd_any_eq;
	bit tie_no_worse, tie_no_better;
	bit tru_no_worse, tru_no_better;

	task automatic clear_dominance();
		rnd_no_worse  = 1'b1;
		rnd_no_better = 1'b1;
		rnd_all_gt    = 1'b1;
		rnd_all_lt    = 1'b1;
		rnd_all_eq    = 1'b1;
		rnd_any_eq    = 1'b0;
		tie_no_worse  = 1'b1;
		tie_no_better = 1'b1;
		tru_no_worse  = 1'b1;
		tru_no_better = 1'b1;
	endtask

	function automatic relation_t rank(input bit up, input bit down);
		if (up && down) begin
			return REL_EQUAL;
		end else if (up) begin
			return REL_DOMINATES;
		end else if (down) begin
			return REL_DOMINATED;
		end
		return REL_INCOMPARABLE;
	endfunction

	// fold one criterion into the flags; on the last beat, encode and restart
	task automatic judge_criterion(input crit_t c, output bit done, output verdict_t v);
		bit r_gt, r_lt, t_gt, t_lt;
		r_gt = c.fr > c.sr;
		r_lt = c.fr < c.sr;
		t_gt = c.ft > c.st;
		t_lt = c.ft < c.st;
		if (r_gt) rnd_no_better = 1'b0;
		if (r_lt) rnd_no_worse = 1'b0;
		if (!r_gt) rnd_all_gt = 1'b0;
		if (!r_lt) rnd_all_lt = 1'b0;
		if (r_gt || r_lt) begin
			rnd_all_eq = 1'b0;
		end else begin
			rnd_any_eq = 1'b1;
		end
		// rounded order first, true values only break a rounded tie
		if (r_gt || (!r_lt && t_gt)) tie_no_better = 1'b0;
		if (r_lt || (!r_gt && t_lt)) tie_no_worse = 1'b0;
		if (t_gt) tru_no_better = 1'b0;
		if (t_lt) tru_no_worse = 1'b0;
		done = c.last;
		v.rel = REL_INCOMPARABLE;
		v.req = rnd_all_eq;
		if (done) begin
			case (c.mode)
				MODE_WEAK_ROUNDED: begin
					v.rel = rank(rnd_no_worse, rnd_no_better);
				end
				MODE_STRICT_ROUNDED: begin
					if (rnd_all_eq) v.rel = REL_EQUAL;
					else if (rnd_any_eq) v.rel = REL_EQUAL_SOME;
					else v.rel = rank(rnd_all_gt, rnd_all_lt);
				end
				MODE_STRONG: begin
					v.rel = rnd_all_eq ? REL_EQUAL : rank(tie_no_worse, tie_no_better);
				end
				default: begin
					v.rel = rank(tru_no_worse, tru_no_better);
				end
			endcase
			clear_dominance();
		end
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_crit(input crit_t c, input bit typed, input verdict_t typed_v);
		bit done;
		verdict_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		mode = c.mode;
		first_true = c.ft;
		first_rounded = c.fr;
		second_true = c.st;
		second_rounded = c.sr;
		last = c.last;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		judge_criterion(c, done, v);
		if (done) verdict_q.push_back(typed ? typed_v : v);
	endtask

	task automatic drain();
		item_valid = 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
	endtask

	function automatic value_t pick_value();
		case ($urandom_range(7))
			0: return V_MIN;
			1: return V_MAX;
			2: return '0;
			3: return value_t'($urandom_range(512)) - value_t'(256);
			default: return value_t'($urandom);
		endcase
	endfunction

	// how: 0 equal, 1 first larger, 2 second larger, 3 unordered
	task automatic order_pair(input int how, output value_t x, output value_t y);
		value_t a, b, lo, hi;
		a = pick_value();
		b = ($urandom_range(3) == 0) ? a + value_t'($urandom_range(1, 3)) : pick_value();
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		case (how)
			0: begin x = a; y = a; end
			1: begin x = hi; y = lo; end
			2: begin x = lo; y = hi; end
			default: begin x = a; y = b; end
		endcase
	endtask

	task automatic run_vectors(input int n_items);
		int sent, len, bias;
		mode_t m;
		crit_t c;
		verdict_t none;
		sent = 0;
		none = '{rel: REL_INCOMPARABLE, req: 1'b0};
		while (sent < n_items) begin
			case ($urandom_range(19))
				0: len = $urandom_range(9, 20);
				1, 2, 3, 4, 5, 6, 7: len = $urandom_range(4, 8);
				default: len = $urandom_range(1, 3);
			endcase
			// most criteria follow a per-vector lean so dominance survives long vectors
			bias = $urandom_range(3);
			m = mode_t'($urandom_range(3));
			for (int i = 0; i < len; i++) begin
				order_pair(($urandom_range(9) < 8) ? bias : $urandom_range(3), c.fr, c.sr);
				order_pair((c.fr == c.sr || $urandom_range(1)) ? $urandom_range(3) : bias,
					c.ft, c.st);
				c.last = (i == len - 1);
				c.mode = c.last ? m : mode_t'($urandom_range(3));
				send_crit(c, 1'b0, none);
			end
			sent += len;
		end
	endtask

	function automatic row_t row(input mode_t m, input value_t ft, input value_t fr,
			input value_t st, input value_t sr, input logic lst, input bit typed,
			input relation_t rel, input logic req);
		row_t r;
		r.c = '{mode: m, ft: ft, fr: fr, st: st, sr: sr, last: lst};
		r.typed = typed;
		r.v = '{rel: rel, req: req};
		return r;
	endfunction

	// receiver: random stall, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall = 1'b1;
			hold_left--;
		end else begin
			result_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (verdict_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected result beat, relation %0d rounded_equal %0d",
						$time, relation, rounded_equal);
			end else begin
				verdict_t exp_v;
				exp_v = verdict_q.pop_front();
				if (relation !== exp_v.rel) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: relation mismatch: expected %0d, actual %0d",
							$time, exp_v.rel, relation);
				end
				if (rounded_equal !== exp_v.req) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: rounded_equal mismatch: expected %0d, actual %0d",
							$time, exp_v.req, rounded_equal);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, STUCK_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		row_t dir_tab [N_DIRECTED];
		crit_t c;
		verdict_t none;
		none = '{rel: REL_INCOMPARABLE, req: 1'b0};
		clear_dominance();
		dir_tab = '{
			// single-criterion vectors at the extremes
			row(MODE_WEAK_ROUNDED, 0, 0, 0, 0, 1, 1, REL_EQUAL, 1),
			row(MODE_WEAK_ROUNDED, 0, V_MAX, 0, V_MIN, 1, 1, REL_DOMINATES, 0),
			row(MODE_WEAK_ROUNDED, 0, V_MIN, 0, V_MAX, 1, 1, REL_DOMINATED, 0),
			row(MODE_STRICT_ROUNDED, 0, V_MIN, 0, V_MIN, 1, 1, REL_EQUAL, 1),
			row(MODE_STRICT_ROUNDED, 0, V_MAX, 0, V_MIN, 1, 1, REL_DOMINATES, 0),
			// mode on a non-last beat must be ignored
			row(MODE_WEAK_TRUE, 5, 7, 9, 7, 0, 0, REL_INCOMPARABLE, 0),
			row(MODE_STRICT_ROUNDED, 0, 1, 0, 0, 1, 1, REL_EQUAL_SOME, 0),
			row(MODE_WEAK_ROUNDED, 0, 10, 0, -10, 0, 0, REL_INCOMPARABLE, 0),
			row(MODE_WEAK_ROUNDED, 0, -10, 0, 10, 1, 1, REL_INCOMPARABLE, 0),
			row(MODE_STRONG, V_MAX, 100, V_MIN, 100, 1, 1, REL_EQUAL, 1),
			// strong: true values break rounded ties
			row(MODE_STRONG, 2, 3, 1, 3, 0, 0, REL_INCOMPARABLE, 0),
			row(MODE_STRONG, 0, 8, 100, 4, 1, 0, REL_INCOMPARABLE, 0),
			row(MODE_STRONG, -1, 0, 1, 0, 0, 0, REL_INCOMPARABLE, 0),
			row(MODE_STRONG, 0, 5, 0, 9, 1, 0, REL_INCOMPARABLE, 0),
			row(MODE_STRONG, 7, 2, 6, 2, 0, 0, REL_INCOMPARABLE, 0),
			row(MODE_STRONG, 0, 1, 0, 2, 1, 0, REL_INCOMPARABLE, 0),
			row(MODE_WEAK_TRUE, V_MAX, 42, V_MIN, 42, 1, 1, REL_DOMINATES, 1),
			row(MODE_WEAK_TRUE, V_MIN, 0, V_MIN, 1, 1, 1, REL_EQUAL, 0),
			row(MODE_WEAK_TRUE, -1, 0, 0, 0, 1, 1, REL_DOMINATED, 1),
			row(MODE_STRICT_ROUNDED, 0, 3, 0, 1, 0, 0, REL_INCOMPARABLE, 0),
			row(MODE_STRICT_ROUNDED, 0, -1, 0, 0, 1, 0, REL_INCOMPARABLE, 0),
			row(MODE_STRICT_ROUNDED, 0, V_MIN, 0, V_MAX, 0, 0, REL_INCOMPARABLE, 0),
			row(MODE_STRICT_ROUNDED, 0, -5, 0, -4, 1, 0, REL_INCOMPARABLE, 0),
			row(MODE_WEAK_ROUNDED, 3, -7, 3, -7, 0, 0, REL_INCOMPARABLE, 0),
			row(MODE_WEAK_ROUNDED, 0, 9, 0, 8, 1, 0, REL_INCOMPARABLE, 0)
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_crit(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].v);
		drain();

		// receiver holds off while single-criterion vectors keep coming
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		for (int i = 0; i < 24; i++) begin
			c.mode = mode_t'($urandom_range(3));
			order_pair($urandom_range(3), c.fr, c.sr);
			order_pair($urandom_range(3), c.ft, c.st);
			c.last = 1'b1;
			send_crit(c, 1'b0, none);
		end
		drain();

		send_idle_pct = 31;
		recv_idle_pct = 87;
		run_vectors(400);
		drain();

		send_idle_pct = 87;
		recv_idle_pct = 31;
		run_vectors(400);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_vectors(400);
		drain();

		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
